/* src/slbm_pkg.sv */
`timescale 1ns / 1ps

package slbm_pkg;

	// cartridge limits and field widths
	localparam int MAX_PRG_BANKS = 16;
	localparam int COUNT_W       = 5;
	localparam int BANK_W        = 4;
	localparam int OFFSET_W      = 18;
	localparam int CHR_BANK_W    = 5;

	localparam logic [COUNT_W-1:0] PRG_COUNT_RESET = 5'd2;
	localparam logic [4:0]         SHIFT_INIT      = 5'h10;

	// bus access kinds
	typedef enum logic [1:0] {
		KIND_CPU_RD = 2'd0,
		KIND_CPU_WR = 2'd1,
		KIND_PPU_RD = 2'd2,
		KIND_PPU_WR = 2'd3
	} kind_e;

	// memory the access lands in
	typedef enum logic [2:0] {
		TGT_NONE    = 3'd0,
		TGT_PRG_RAM = 3'd1,
		TGT_PRG_ROM = 3'd2,
		TGT_REG     = 3'd3,
		TGT_CHR     = 3'd4,
		TGT_NT_A    = 3'd5,
		TGT_NT_B    = 3'd6,
		TGT_RSVD    = 3'd7
	} target_e;

	// nametable mirroring
	typedef enum logic [1:0] {
		MIR_ONE_LO = 2'd0,
		MIR_ONE_HI = 2'd1,
		MIR_VERT   = 2'd2,
		MIR_HORIZ  = 2'd3
	} mirror_e;

	// prg banking modes
	typedef enum logic [1:0] {
		PRG_32K_A  = 2'd0,
		PRG_32K_B  = 2'd1,
		PRG_FIX_LO = 2'd2,
		PRG_FIX_HI = 2'd3
	} prg_banking_e;

	// register select from address bits 14:13
	typedef enum logic [1:0] {
		REG_CTRL = 2'd0,
		REG_CHR0 = 2'd1,
		REG_CHR1 = 2'd2,
		REG_PRG  = 2'd3
	} reg_sel_e;

	// config side to mapping side
	typedef struct packed {
		logic              wr;
		logic [BANK_W-1:0] last_bank;
	} cfg_t;

	typedef struct packed {
		logic [BANK_W-1:0] lo;
		logic [BANK_W-1:0] hi;
	} bank_pair_t;

	// one translated access
	typedef struct packed {
		target_e               target;
		logic [OFFSET_W-1:0]   offset;
		mirror_e               mirroring;
		prg_banking_e          prg_banking;
		logic                  chr_split;
		logic [CHR_BANK_W-1:0] chr_bank_lo;
		logic [CHR_BANK_W-1:0] chr_bank_hi;
	} result_t;

	// highest bank index with the count saturated to 1..MAX_PRG_BANKS
	function automatic logic [BANK_W-1:0] last_bank(input logic [COUNT_W-1:0] count);
		logic [COUNT_W-1:0] n;
		begin
			n = count;
			if (n == '0) begin
				n = COUNT_W'(1);
			end
			if (n > COUNT_W'(MAX_PRG_BANKS)) begin
				n = COUNT_W'(MAX_PRG_BANKS);
			end
			last_bank = BANK_W'(n - COUNT_W'(1));
		end
	endfunction

	// prg bank pair for a mode and a select value
	function automatic bank_pair_t update_banks(input prg_banking_e mode,
			input logic [BANK_W-1:0] sel, input logic [BANK_W-1:0] last);
		bank_pair_t p;
		begin
			unique case (mode)
				PRG_32K_A, PRG_32K_B: begin
					p.lo = {sel[BANK_W-1:1], 1'b0};
					p.hi = {sel[BANK_W-1:1], 1'b1};
				end
				PRG_FIX_LO: begin
					p.lo = '0;
					p.hi = sel;
				end
				default: begin
					p.lo = sel;
					p.hi = last;
				end
			endcase
			update_banks = p;
		end
	endfunction

endpackage

/* src/serial_loaded_bank_mapper_core.sv */
`timescale 1ns / 1ps

// Serial-loaded bank mapper (MMC1 style). Each item is one CPU or PPU bus access and gives
// one result: the memory it lands in, the byte offset there, and the mapper's mirroring,
// PRG mode and CHR fields as they stand after the access. An item passes an input register,
// then a result register, and a new item is taken every cycle unless a result waits with
// out_ready low; the state update and translation sit between those registers,
// so back-to-back writes into the serial shift register need no stall. CHR banks are
// reported, not applied to CHR offsets. The PRG bank count register (reset 2) is read at
// APB address 0, written at any address, and reloads the upper PRG bank; write it only idle.
module serial_loaded_bank_mapper_core
	import slbm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [1:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            kind,
	input  logic [15:0]           address,
	input  logic [7:0]            data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            target,
	output logic [OFFSET_W-1:0]   offset,
	output logic [1:0]            mirroring,
	output logic [1:0]            prg_banking,
	output logic                  chr_split,
	output logic [CHR_BANK_W-1:0] chr_bank_lo,
	output logic [CHR_BANK_W-1:0] chr_bank_hi
);

	cfg_t        cfg;
	logic        valid_s1;
	kind_e       kind_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;
	logic        advance;
	result_t     res;
	result_t     res_q;
	logic        out_valid_q;

	slbm_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1    <= kind_e'(kind);
			address_s1 <= address;
			data_s1    <= data;
		end
	end

	slbm_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cfg     (cfg),
		.kind    (kind_s1),
		.address (address_s1),
		.data    (data_s1),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign target      = res_q.target;
	assign offset      = res_q.offset;
	assign mirroring   = res_q.mirroring;
	assign prg_banking = res_q.prg_banking;
	assign chr_split   = res_q.chr_split;
	assign chr_bank_lo = res_q.chr_bank_lo;
	assign chr_bank_hi = res_q.chr_bank_hi;

endmodule

/* src/slbm_apb.sv */
`timescale 1ns / 1ps

module slbm_apb
	import slbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [COUNT_W-1:0] count_q;
	logic               wr;

	// single register; writes at every address land in it, reads only at address 0
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= PRG_COUNT_RESET;
		end else if (wr) begin
			count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// read back at address 0
	always_comb begin
		prdata = '0;
		if (paddr == 2'b00) begin
			prdata[COUNT_W-1:0] = count_q;
		end
	end

	// new last bank goes out with the write strobe
	assign cfg.wr        = wr;
	assign cfg.last_bank = last_bank(wr ? pwdata[COUNT_W-1:0] : count_q);

endmodule

/* src/slbm_map.sv */
`timescale 1ns / 1ps

module slbm_map
	import slbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  cfg_t        cfg,
	input  kind_e       kind,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output result_t     res
);

	// mapper state
	logic [4:0]            shift_q;
	mirror_e               mirror_q;
	prg_banking_e          prg_banking_q;
	logic                  chr_split_q;
	logic [BANK_W-1:0]     prg_sel_q;
	logic [BANK_W-1:0]     bank_lo_q;
	logic [BANK_W-1:0]     bank_hi_q;
	logic [CHR_BANK_W-1:0] chr_lo_q;
	logic [CHR_BANK_W-1:0] chr_hi_q;
	logic [BANK_W-1:0]     last_q;

	logic [4:0]            shift_d;
	mirror_e               mirror_d;
	prg_banking_e          prg_banking_d;
	logic                  chr_split_d;
	logic [BANK_W-1:0]     prg_sel_d;
	bank_pair_t            banks_d;
	logic [CHR_BANK_W-1:0] chr_lo_d;
	logic [CHR_BANK_W-1:0] chr_hi_d;

	logic [4:0]        shifted;
	logic [BANK_W-1:0] rom_bank;
	logic [13:0]       ppu_a;
	logic              upd_banks;

	// serial port and register commit
	always_comb begin
		shift_d       = shift_q;
		mirror_d      = mirror_q;
		prg_banking_d = prg_banking_q;
		chr_split_d   = chr_split_q;
		prg_sel_d     = prg_sel_q;
		chr_lo_d      = chr_lo_q;
		chr_hi_d      = chr_hi_q;
		upd_banks     = 1'b0;
		shifted       = {data[0], shift_q[4:1]};
		if (kind == KIND_CPU_WR && address[15]) begin
			if (data[7]) begin
				prg_banking_d = PRG_FIX_HI;
				shift_d       = SHIFT_INIT;
				upd_banks     = 1'b1;
			end else if (!shift_q[0]) begin
				shift_d = shifted;
			end else begin
				shift_d = SHIFT_INIT;
				unique case (reg_sel_e'(address[14:13]))
					REG_CTRL: begin
						mirror_d      = mirror_e'(shifted[1:0]);
						prg_banking_d = prg_banking_e'(shifted[3:2]);
						chr_split_d   = shifted[4];
						upd_banks     = 1'b1;
					end
					REG_CHR0: begin
						if (chr_split_q) begin
							chr_lo_d = shifted;
						end else begin
							chr_lo_d = {shifted[4:1], 1'b0};
							chr_hi_d = {shifted[4:1], 1'b1};
						end
					end
					REG_CHR1: begin
						chr_hi_d = shifted;
					end
					default: begin
						prg_sel_d = shifted[BANK_W-1:0];
						upd_banks = 1'b1;
					end
				endcase
			end
		end
		if (upd_banks) begin
			banks_d = update_banks(prg_banking_d, prg_sel_d, last_q);
		end else begin
			banks_d.lo = bank_lo_q;
			banks_d.hi = bank_hi_q;
		end
	end

	// state update, config write reloads the upper bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q       <= SHIFT_INIT;
			mirror_q      <= MIR_HORIZ;
			prg_banking_q <= PRG_32K_A;
			chr_split_q   <= 1'b0;
			prg_sel_q     <= '0;
			bank_lo_q     <= '0;
			bank_hi_q     <= last_bank(PRG_COUNT_RESET);
			chr_lo_q      <= '0;
			chr_hi_q      <= '0;
			last_q        <= last_bank(PRG_COUNT_RESET);
		end else if (cfg.wr) begin
			last_q    <= cfg.last_bank;
			bank_hi_q <= cfg.last_bank;
		end else if (advance) begin
			shift_q       <= shift_d;
			mirror_q      <= mirror_d;
			prg_banking_q <= prg_banking_d;
			chr_split_q   <= chr_split_d;
			prg_sel_q     <= prg_sel_d;
			bank_lo_q     <= banks_d.lo;
			bank_hi_q     <= banks_d.hi;
			chr_lo_q      <= chr_lo_d;
			chr_hi_q      <= chr_hi_d;
		end
	end

	// address translation
	assign rom_bank = address[14] ? bank_hi_q : bank_lo_q;
	assign ppu_a    = address[13:0];

	always_comb begin
		res.target = TGT_NONE;
		res.offset = '0;
		if (!kind[1]) begin
			if (address[15]) begin
				if (kind == KIND_CPU_WR) begin
					res.target = TGT_REG;
				end else begin
					res.target = TGT_PRG_ROM;
					res.offset = {rom_bank, address[13:0]};
				end
			end else if (address[14:13] == 2'b11) begin
				res.target = TGT_PRG_RAM;
				res.offset = {5'b0, address[12:0]};
			end
		end else if (ppu_a[13:12] == 2'b10) begin
			res.offset = {8'b0, ppu_a[9:0]};
			unique case (mirror_q)
				MIR_ONE_LO: res.target = TGT_NT_A;
				MIR_ONE_HI: res.target = TGT_NT_B;
				MIR_VERT:   res.target = ppu_a[10] ? TGT_NT_B : TGT_NT_A;
				default:    res.target = ppu_a[11] ? TGT_NT_B : TGT_NT_A;
			endcase
		end else begin
			res.target = TGT_CHR;
			res.offset = {4'b0, ppu_a};
		end
		res.mirroring   = mirror_d;
		res.prg_banking = prg_banking_d;
		res.chr_split   = chr_split_d;
		res.chr_bank_lo = chr_lo_d;
		res.chr_bank_hi = chr_hi_d;
	end

endmodule

/* src/slbm_checker.sv */
`timescale 1ns / 1ps

module slbm_assert
	import slbm_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [2:0]          target,
	input logic [OFFSET_W-1:0] offset,
	input logic                in_ready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(target) && $stable(offset))
		else $error("result changed while stalled");

	// the spare target code never shows
	a_target_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> target != TGT_RSVD)
		else $error("reserved target code");

	// unmapped and register accesses carry no offset
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target == TGT_NONE || target == TGT_REG) |-> offset == '0)
		else $error("nonzero offset for none or register");

	// nametable offsets stay inside one 1K table
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (target == TGT_NT_A || target == TGT_NT_B)
			|-> offset[OFFSET_W-1:10] == '0)
		else $error("nametable offset out of range");

	// with no result waiting the input side is always open
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty result register");

endmodule

bind serial_loaded_bank_mapper_core slbm_assert u_slbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.target    (target),
	.offset    (offset),
	.in_ready  (in_ready)
);
